// ===== rtl/ittd_pkg.sv =====
package ittd_pkg;

    // Gesture codes reported on gesture_code
    localparam logic [2:0] GC_NONE  = 3'd0;
    localparam logic [2:0] GC_X_POS = 3'd1;
    localparam logic [2:0] GC_X_NEG = 3'd2;
    localparam logic [2:0] GC_Z_POS = 3'd3;
    localparam logic [2:0] GC_Z_NEG = 3'd4;
    localparam logic [2:0] GC_Y_ANY = 3'd5;

    // Orientation state, also the orient_event code
    typedef enum logic [1:0] {
        ORIENT_LEVEL = 2'd0,
        ORIENT_DOWN  = 2'd1,
        ORIENT_UP    = 2'd2
    } orient_t;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_GESTURE_THR = 3'd0,
        REG_ORIENT_THR  = 3'd1,
        REG_COOLDOWN_MS = 3'd2,
        REG_HOLD_MS     = 3'd3,
        REG_ALPHA_SHIFT = 3'd4,
        REG_DOMINANCE   = 3'd5
    } reg_index_t;

    localparam int RegAddrWidth = 5;

    // Reset values of the configuration registers
    localparam logic [14:0] GESTURE_THR_RST = 15'd640;
    localparam logic [14:0] ORIENT_THR_RST  = 15'd15729;
    localparam logic [15:0] COOLDOWN_MS_RST = 16'd800;
    localparam logic [15:0] HOLD_MS_RST     = 16'd500;
    localparam logic [3:0]  ALPHA_SHIFT_RST = 4'd2;
    localparam logic [5:0]  DOMINANCE_RST   = 6'd13;

    // Outcome of the dominant axis search
    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } axis_sel_t;

endpackage

// ===== rtl/imu_tilt_gesture_detector_unit.sv =====
// Tilt gesture and orientation detector for an inertial sensor stream.
//
// Sample channel (sample_valid / sample_ready) carries one request per sensor
// sample: active flag, raw Y acceleration, three gyro rates and a millisecond
// timestamp. Result channel (result_valid / result_ready) returns exactly one
// result per request: gesture_code, orient_event and cooling_down, in order.
//
// Datapath: an input register feeds one pass of logic (three EMA filters,
// dominant axis search with small ratio multipliers, hold and cooldown
// timers) that updates all state and loads the result register. A request
// is accepted every cycle while the receiver does not stall; it passes the
// input and then the result register. Throughput is one request per clock
// with no stall, set by the single pass from input to result register.
//
// When the receiver stalls, the result register holds, the input register
// fills and then sample_ready drops until result_ready returns.
// Reset (rst_n low, asynchronous) empties both registers, clears filters and
// timers, and loads the configuration registers with their defaults.
// Configuration is through the APB port; write it only while no request is
// in flight. Inactive requests leave all state untouched and return zeros.
module imu_tilt_gesture_detector_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // APB configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ittd_pkg::RegAddrWidth-1:0]    paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // Sample channel
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  logic                                 active,
    input  logic signed [15:0]                   accel_y,
    input  logic signed [15:0]                   gyro_x,
    input  logic signed [15:0]                   gyro_y,
    input  logic signed [15:0]                   gyro_z,
    input  logic [31:0]                          now_ms,
    // Result channel
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic [2:0]                           gesture_code,
    output logic [1:0]                           orient_event,
    output logic                                 cooling_down
);
    import ittd_pkg::*;

    localparam int FW = 16 + FRAC_BITS;

    // Configuration registers
    logic [14:0] gesture_thr_reg;
    logic [14:0] orient_thr_reg;
    logic [15:0] cooldown_ms_reg;
    logic [15:0] hold_ms_reg;
    logic [3:0]  alpha_shift_reg;
    logic [5:0]  dominance_reg;
    logic        cfg_write;

    // Input register
    logic               in_valid_reg;
    logic               active_reg;
    logic signed [15:0] accel_y_reg;
    logic signed [15:0] gyro_x_reg;
    logic signed [15:0] gyro_y_reg;
    logic signed [15:0] gyro_z_reg;
    logic [31:0]        now_ms_reg;

    // Result register
    logic       out_valid_reg;
    logic [2:0] gesture_code_reg;
    logic [1:0] orient_event_reg;
    logic       cooling_down_reg;
    logic [2:0] gesture_code_next;
    logic [1:0] orient_event_next;
    logic       cooling_down_next;

    // Detector state
    orient_t     orient_reg;
    orient_t     orient_next;
    logic        hold_armed_reg;
    logic        hold_armed_next;
    logic [31:0] hold_start_reg;
    logic [31:0] hold_start_next;
    logic        cool_active_reg;
    logic        cool_active_next;
    logic [31:0] cool_start_reg;
    logic [31:0] cool_start_next;

    logic        advance;
    logic        update;
    logic signed [FW-1:0] filt_x;
    logic signed [FW-1:0] filt_y;
    logic signed [FW-1:0] filt_z;
    axis_sel_t   sel;

    logic signed [16:0] ay_ext;
    logic signed [16:0] othr_ext;
    logic        is_down;
    logic        is_up;
    orient_t     want;
    logic [31:0] hold_elapsed;
    logic [31:0] cool_elapsed;
    logic        cooling;
    logic        fire;

    // ---------------------------------------------------------------
    // APB register file: writes on the access phase, zero wait states
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gesture_thr_reg <= GESTURE_THR_RST;
            orient_thr_reg  <= ORIENT_THR_RST;
            cooldown_ms_reg <= COOLDOWN_MS_RST;
            hold_ms_reg     <= HOLD_MS_RST;
            alpha_shift_reg <= ALPHA_SHIFT_RST;
            dominance_reg   <= DOMINANCE_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[RegAddrWidth-1:2])
                REG_GESTURE_THR: gesture_thr_reg <= pwdata[14:0];
                REG_ORIENT_THR:  orient_thr_reg  <= pwdata[14:0];
                REG_COOLDOWN_MS: cooldown_ms_reg <= pwdata[15:0];
                REG_HOLD_MS:     hold_ms_reg     <= pwdata[15:0];
                REG_ALPHA_SHIFT: alpha_shift_reg <= pwdata[3:0];
                REG_DOMINANCE:   dominance_reg   <= pwdata[5:0];
                default:         ; // drop writes beyond the register list
            endcase
        end
    end

    always_comb
    begin
        case (paddr[RegAddrWidth-1:2])
            REG_GESTURE_THR: prdata = {17'd0, gesture_thr_reg};
            REG_ORIENT_THR:  prdata = {17'd0, orient_thr_reg};
            REG_COOLDOWN_MS: prdata = {16'd0, cooldown_ms_reg};
            REG_HOLD_MS:     prdata = {16'd0, hold_ms_reg};
            REG_ALPHA_SHIFT: prdata = {28'd0, alpha_shift_reg};
            REG_DOMINANCE:   prdata = {26'd0, dominance_reg};
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake: advance moves the held request into the result register
    // ---------------------------------------------------------------
    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;
    assign update       = advance && active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                in_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input payload: load on accept
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            active_reg  <= active;
            accel_y_reg <= accel_y;
            gyro_x_reg  <= gyro_x;
            gyro_y_reg  <= gyro_y;
            gyro_z_reg  <= gyro_z;
            now_ms_reg  <= now_ms;
        end
    end

    // ---------------------------------------------------------------
    // Gyro smoothing, one filter per axis, state updated on active requests
    // ---------------------------------------------------------------
    ittd_ema #(.FRAC_BITS(FRAC_BITS)) u_ema_x (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (update),
        .sample      (gyro_x_reg),
        .alpha_shift (alpha_shift_reg),
        .filt        (filt_x)
    );

    ittd_ema #(.FRAC_BITS(FRAC_BITS)) u_ema_y (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (update),
        .sample      (gyro_y_reg),
        .alpha_shift (alpha_shift_reg),
        .filt        (filt_y)
    );

    ittd_ema #(.FRAC_BITS(FRAC_BITS)) u_ema_z (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (update),
        .sample      (gyro_z_reg),
        .alpha_shift (alpha_shift_reg),
        .filt        (filt_z)
    );

    // Dominant axis and threshold check on the freshly filtered rates
    ittd_axis_select #(.FRAC_BITS(FRAC_BITS)) u_axis_select (
        .filt_x            (filt_x),
        .filt_y            (filt_y),
        .filt_z            (filt_z),
        .dominance_tenths  (dominance_reg),
        .gesture_threshold (gesture_thr_reg),
        .sel               (sel)
    );

    // ---------------------------------------------------------------
    // Orientation hold and gesture cooldown
    // ---------------------------------------------------------------
    always_comb
    begin
        ay_ext       = {accel_y_reg[15], accel_y_reg};
        othr_ext     = {2'b00, orient_thr_reg};
        is_down      = ay_ext > othr_ext;
        is_up        = ay_ext < -othr_ext;
        want         = is_down ? ORIENT_DOWN : ORIENT_UP;
        hold_elapsed = now_ms_reg - hold_start_reg;
        cool_elapsed = now_ms_reg - cool_start_reg;

        // Cooldown ends on the first sample at or past its length
        cooling = cool_active_reg && (cool_elapsed < {16'd0, cooldown_ms_reg});
        fire    = !cooling && sel.hit;

        orient_next       = orient_reg;
        hold_armed_next   = hold_armed_reg;
        hold_start_next   = hold_start_reg;
        orient_event_next = ORIENT_LEVEL;

        if (is_down || is_up)
        begin
            if (orient_reg != want)
            begin
                // New orientation: arm the hold timer
                orient_next     = want;
                hold_armed_next = 1'b1;
                hold_start_next = now_ms_reg;
            end
            else if (hold_armed_reg && (hold_elapsed > {16'd0, hold_ms_reg}))
            begin
                // Held long enough: report once, then disarm
                hold_armed_next   = 1'b0;
                orient_event_next = want;
            end
        end
        else
        begin
            orient_next     = ORIENT_LEVEL;
            hold_armed_next = 1'b0;
        end

        cool_active_next  = fire || cooling;
        cool_start_next   = fire ? now_ms_reg : cool_start_reg;
        gesture_code_next = fire ? sel.code : GC_NONE;
        cooling_down_next = cooling;

        // Inactive sample: report nothing
        if (!active_reg)
        begin
            gesture_code_next = GC_NONE;
            orient_event_next = ORIENT_LEVEL;
            cooling_down_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg      <= ORIENT_LEVEL;
            hold_armed_reg  <= 1'b0;
            hold_start_reg  <= '0;
            cool_active_reg <= 1'b0;
            cool_start_reg  <= '0;
        end
        else if (update)
        begin
            orient_reg      <= orient_next;
            hold_armed_reg  <= hold_armed_next;
            hold_start_reg  <= hold_start_next;
            cool_active_reg <= cool_active_next;
            cool_start_reg  <= cool_start_next;
        end
    end

    // Result payload: load when the request advances, hold while stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            gesture_code_reg <= gesture_code_next;
            orient_event_reg <= orient_event_next;
            cooling_down_reg <= cooling_down_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign gesture_code = gesture_code_reg;
    assign orient_event = orient_event_reg;
    assign cooling_down = cooling_down_reg;

endmodule

// ===== rtl/ittd_ema.sv =====
module ittd_ema #(
    parameter int FRAC_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      update,
    input  logic signed [15:0]        sample,
    input  logic [3:0]                alpha_shift,
    output logic signed [15+FRAC_BITS:0] filt
);
    localparam int FW = 16 + FRAC_BITS;

    logic signed [FW-1:0] filt_reg;
    logic signed [FW-1:0] filt_next;
    logic signed [FW-1:0] target;
    logic signed [FW:0]   diff;
    logic signed [FW:0]   step;
    logic signed [FW:0]   sum;

    // F += floor((target - F) / 2^alpha); arithmetic shift floors
    always_comb
    begin
        target    = {sample, {FRAC_BITS{1'b0}}};
        diff      = {target[FW-1], target} - {filt_reg[FW-1], filt_reg};
        step      = diff >>> alpha_shift;
        sum       = {filt_reg[FW-1], filt_reg} + step;
        filt_next = sum[FW-1:0];
    end

    assign filt = filt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= '0;
        end
        else if (update)
        begin
            filt_reg <= filt_next;
        end
    end

endmodule

// ===== rtl/ittd_axis_select.sv =====
module ittd_axis_select #(
    parameter int FRAC_BITS = 8
) (
    input  logic signed [15+FRAC_BITS:0] filt_x,
    input  logic signed [15+FRAC_BITS:0] filt_y,
    input  logic signed [15+FRAC_BITS:0] filt_z,
    input  logic [5:0]                   dominance_tenths,
    input  logic [14:0]                  gesture_threshold,
    output ittd_pkg::axis_sel_t          sel
);
    import ittd_pkg::*;

    localparam int FW = 16 + FRAC_BITS;
    localparam int MW = FW + 6;

    logic [FW-1:0] mag_x;
    logic [FW-1:0] mag_y;
    logic [FW-1:0] mag_z;
    logic [FW-1:0] mag_sel;
    logic [FW-1:0] thr_ext;
    logic          dom_x;
    logic          dom_y;
    logic          dom_z;

    function automatic logic [FW-1:0] magnitude(input logic [FW-1:0] v);
        magnitude = v[FW-1] ? (~v + FW'(1)) : v;
    endfunction

    // 10*|a| > ratio*|b| and 10*|a| > ratio*|c|
    function automatic logic dominates(input logic [FW-1:0] a,
                                       input logic [FW-1:0] b,
                                       input logic [FW-1:0] c,
                                       input logic [5:0]    ratio);
        logic [MW-1:0] a10;
        logic [MW-1:0] bs;
        logic [MW-1:0] cs;
        a10 = {6'd0, a} * MW'(10);
        bs  = {6'd0, b} * {{(MW-6){1'b0}}, ratio};
        cs  = {6'd0, c} * {{(MW-6){1'b0}}, ratio};
        dominates = (a10 > bs) && (a10 > cs);
    endfunction

    always_comb
    begin
        mag_x   = magnitude(filt_x);
        mag_y   = magnitude(filt_y);
        mag_z   = magnitude(filt_z);
        thr_ext = {1'b0, gesture_threshold, {FRAC_BITS{1'b0}}};
        dom_x   = dominates(mag_x, mag_y, mag_z, dominance_tenths);
        dom_y   = dominates(mag_y, mag_z, mag_x, dominance_tenths);
        dom_z   = dominates(mag_z, mag_x, mag_y, dominance_tenths);

        sel.hit  = 1'b0;
        sel.code = GC_NONE;
        mag_sel  = '0;
        // Priority X, then Y, then Z
        if (dom_x)
        begin
            mag_sel  = mag_x;
            sel.code = filt_x[FW-1] ? GC_X_NEG : GC_X_POS;
        end
        else if (dom_y)
        begin
            mag_sel  = mag_y;
            sel.code = GC_Y_ANY;
        end
        else if (dom_z)
        begin
            mag_sel  = mag_z;
            sel.code = filt_z[FW-1] ? GC_Z_NEG : GC_Z_POS;
        end
        sel.hit = (dom_x || dom_y || dom_z) && (mag_sel > thr_ext);
    end

endmodule
